FILE: sv/vn2d_pkg.sv
// ----------------------------------------------------------------------------
// vn2d_pkg
// Shared types and constants of the 2-D vector normalize pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vn2d_pkg;

  localparam int COORD_W    = 16;
  localparam int VEC_W      = 17;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int MAG_W      = 17;
  localparam int REM_W      = 19;
  localparam int QUO_W      = 15;
  localparam int UNIT_W     = 16;
  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 15;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
  } vec_t;

endpackage

`default_nettype wire

FILE: sv/vn2d_sq.sv
// ----------------------------------------------------------------------------
// vn2d_sq
// Difference vector, squares of its components and their sum (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module vn2d_sq (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  us_valid,
  output logic                                 us_ready,
  input  wire  [vn2d_pkg::COORD_W-1:0]         start_x,
  input  wire  [vn2d_pkg::COORD_W-1:0]         start_y,
  input  wire  [vn2d_pkg::COORD_W-1:0]         end_x,
  input  wire  [vn2d_pkg::COORD_W-1:0]         end_y,
  output logic                                 ds_valid,
  input  wire                                  ds_ready,
  output vn2d_pkg::vec_t                       ds_vec,
  output logic [vn2d_pkg::SUM_W-1:0]           ds_sum
);

  logic [2:0] v_r;
  logic [3:0] en;

  vn2d_pkg::vec_t                     vec1_nxt, vec1_r, vec2_r, vec3_r;
  logic [vn2d_pkg::COORD_W-1:0]       ax, ay;
  logic [vn2d_pkg::SQ_W-1:0]          sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  logic [vn2d_pkg::SUM_W-1:0]         sum_nxt, sum_r;
  logic [vn2d_pkg::VEC_W-1:0]         nx, ny;

  assign en[3] = ds_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign us_ready = en[0];

  always_comb begin
    vec1_nxt.x = {end_x[15], end_x} - {start_x[15], start_x};
    vec1_nxt.y = {end_y[15], end_y} - {start_y[15], start_y};
    nx = -vec1_r.x;
    ny = -vec1_r.y;
    ax = vec1_r.x[16] ? nx[15:0] : vec1_r.x[15:0];
    ay = vec1_r.y[16] ? ny[15:0] : vec1_r.y[15:0];
    sqx_nxt = ax * ax;
    sqy_nxt = ay * ay;
    sum_nxt = {2'b00, sqx_r} + {2'b00, sqy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= us_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      vec1_r <= vec1_nxt;
    end
    if (en[1]) begin
      vec2_r <= vec1_r;
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
    end
    if (en[2]) begin
      vec3_r <= vec2_r;
      sum_r  <= sum_nxt;
    end
  end

  assign ds_valid = v_r[2];
  assign ds_vec   = vec3_r;
  assign ds_sum   = sum_r;

endmodule

`default_nettype wire

FILE: sv/vn2d_sqrt.sv
// ----------------------------------------------------------------------------
// vn2d_sqrt
// Floor square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2d_sqrt (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  us_valid,
  output logic                                 us_ready,
  input  vn2d_pkg::vec_t                       us_vec,
  input  wire  [vn2d_pkg::SUM_W-1:0]           us_sum,
  output logic                                 ds_valid,
  input  wire                                  ds_ready,
  output vn2d_pkg::vec_t                       ds_vec,
  output logic [vn2d_pkg::MAG_W-1:0]           ds_mag
);

  localparam int NS = vn2d_pkg::SQRT_STEPS;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  vn2d_pkg::vec_t              vec_r  [0:NS-1];
  logic [vn2d_pkg::SUM_W-1:0]  n_r    [0:NS-1];
  logic [vn2d_pkg::REM_W-1:0]  rem_r  [0:NS-1];
  logic [vn2d_pkg::MAG_W-1:0]  root_r [0:NS-1];

  assign en[NS]   = ds_ready;
  assign us_ready = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                        v_in;
    vn2d_pkg::vec_t              vec_in;
    logic [vn2d_pkg::SUM_W-1:0]  n_in;
    logic [vn2d_pkg::REM_W-1:0]  rem_in;
    logic [vn2d_pkg::MAG_W-1:0]  root_in;
    logic [vn2d_pkg::REM_W+1:0]  cur, trial;
    logic                        ge;
    logic [vn2d_pkg::REM_W-1:0]  rem_nxt;
    logic [vn2d_pkg::MAG_W-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = us_valid;
      assign vec_in  = us_vec;
      assign n_in    = us_sum;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign vec_in  = vec_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign en[k] = !v_r[k] || en[k+1];

    always_comb begin
      cur      = {rem_in, n_in[vn2d_pkg::SUM_W-1-2*k -: 2]};
      trial    = {2'b00, root_in, 2'b01};
      ge       = cur >= trial;
      rem_nxt  = ge ? vn2d_pkg::REM_W'(cur - trial) : cur[vn2d_pkg::REM_W-1:0];
      root_nxt = {root_in[vn2d_pkg::MAG_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        vec_r[k]  <= vec_in;
        n_r[k]    <= n_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign ds_valid = v_r[NS-1];
  assign ds_vec   = vec_r[NS-1];
  assign ds_mag   = root_r[NS-1];

endmodule

`default_nettype wire

FILE: sv/vn2d_div.sv
// ----------------------------------------------------------------------------
// vn2d_div
// Unit vector: two restoring dividers, one quotient bit per stage, then sign.
// ----------------------------------------------------------------------------
`default_nettype none

module vn2d_div (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  us_valid,
  output logic                                 us_ready,
  input  vn2d_pkg::vec_t                       us_vec,
  input  wire  [vn2d_pkg::MAG_W-1:0]           us_mag,
  output logic                                 ds_valid,
  input  wire                                  ds_ready,
  output vn2d_pkg::vec_t                       ds_vec,
  output logic [vn2d_pkg::MAG_W-1:0]           ds_mag,
  output logic [vn2d_pkg::UNIT_W-1:0]          ds_unit_x,
  output logic [vn2d_pkg::UNIT_W-1:0]          ds_unit_y
);

  localparam int NS = vn2d_pkg::DIV_STEPS + 2;
  localparam int MW = vn2d_pkg::MAG_W;
  localparam int QW = vn2d_pkg::QUO_W;
  localparam int UW = vn2d_pkg::UNIT_W;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  vn2d_pkg::vec_t  vec_r  [0:NS-1];
  logic [MW-1:0]   mag_r  [0:NS-1];
  logic            zero_r [0:NS-1];
  logic [1:0]      neg_r  [0:NS-1];
  logic [1:0]      lsb_r;
  logic [MW-1:0]   rem_r  [0:NS-2][0:1];
  logic [QW-1:0]   quo_r  [0:NS-2][0:1];
  logic [UW-1:0]   unit_r [0:1];

  assign en[NS]   = ds_ready;
  assign us_ready = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign en[k] = !v_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= (k == 0) ? us_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        if (k == 0) begin
          vec_r[k]  <= us_vec;
          mag_r[k]  <= us_mag;
          zero_r[k] <= us_mag == '0;
          neg_r[k]  <= {us_vec.y[MW-1], us_vec.x[MW-1]};
        end else begin
          vec_r[k]  <= vec_r[(k == 0) ? 0 : k-1];
          mag_r[k]  <= mag_r[(k == 0) ? 0 : k-1];
          zero_r[k] <= zero_r[(k == 0) ? 0 : k-1];
          neg_r[k]  <= neg_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_lane
    logic [vn2d_pkg::VEC_W-1:0] d, dn;
    logic [UW-1:0]              a;
    logic [UW-1:0]              qs;

    always_comb begin
      d  = (c == 0) ? us_vec.x : us_vec.y;
      dn = -d;
      a  = d[vn2d_pkg::VEC_W-1] ? dn[UW-1:0] : d[UW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        rem_r[0][c] <= {2'b00, a[UW-1:1]};
        quo_r[0][c] <= '0;
        lsb_r[c]    <= a[0];
      end
    end

    for (genvar k = 1; k <= vn2d_pkg::DIV_STEPS; k++) begin : g_step
      logic [MW:0]   cur;
      logic          ge;
      logic [MW-1:0] rem_nxt;

      always_comb begin
        cur     = {rem_r[k-1][c], (k == 1) ? lsb_r[c] : 1'b0};
        ge      = cur >= {1'b0, mag_r[k-1]};
        rem_nxt = ge ? MW'(cur - {1'b0, mag_r[k-1]}) : cur[MW-1:0];
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k][c] <= rem_nxt;
          quo_r[k][c] <= {quo_r[k-1][c][QW-2:0], ge};
        end
      end
    end

    always_comb begin
      qs = {1'b0, quo_r[NS-2][c]};
    end

    always_ff @(posedge clk) begin
      if (en[NS-1]) begin
        if (zero_r[NS-2]) begin
          unit_r[c] <= '0;
        end else if (neg_r[NS-2][c]) begin
          unit_r[c] <= -qs;
        end else begin
          unit_r[c] <= qs;
        end
      end
    end
  end

  assign ds_valid  = v_r[NS-1];
  assign ds_vec    = vec_r[NS-1];
  assign ds_mag    = mag_r[NS-1];
  assign ds_unit_x = unit_r[0];
  assign ds_unit_y = unit_r[1];

endmodule

`default_nettype wire

FILE: sv/vector_normalize_2d_unit.sv
// ----------------------------------------------------------------------------
// vector_normalize_2d_unit
// Difference vector, floor length and Q1.14 unit vector of a 2-D segment.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the output stalls, and three
// stages form the difference and sum of squares, seventeen stages of the
// square root resolve one length bit each, and seventeen stages hold the
// operand setup, fifteen quotient bits of the two dividers and the sign step.
// Each stage stalls only when the stage after it is full, so gaps close up
// while the output register waits to be taken. A zero length gives a zero
// unit vector.
`default_nettype none

module vector_normalize_2d_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // start_x, start_y, end_x, end_y
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [87:0] out_tdata   // vec_x, vec_y, magnitude, unit_x, unit_y, zero pad
);

  logic                                sq_valid, sq_ready;
  vn2d_pkg::vec_t                      sq_vec;
  logic [vn2d_pkg::SUM_W-1:0]          sq_sum;
  logic                                rt_valid, rt_ready;
  vn2d_pkg::vec_t                      rt_vec;
  logic [vn2d_pkg::MAG_W-1:0]          rt_mag;
  vn2d_pkg::vec_t                      o_vec;
  logic [vn2d_pkg::MAG_W-1:0]          o_mag;
  logic [vn2d_pkg::UNIT_W-1:0]         o_unit_x, o_unit_y;

  vn2d_sq u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .us_valid (in_tvalid),
    .us_ready (in_tready),
    .start_x  (in_tdata[15:0]),
    .start_y  (in_tdata[31:16]),
    .end_x    (in_tdata[47:32]),
    .end_y    (in_tdata[63:48]),
    .ds_valid (sq_valid),
    .ds_ready (sq_ready),
    .ds_vec   (sq_vec),
    .ds_sum   (sq_sum)
  );

  vn2d_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .us_valid (sq_valid),
    .us_ready (sq_ready),
    .us_vec   (sq_vec),
    .us_sum   (sq_sum),
    .ds_valid (rt_valid),
    .ds_ready (rt_ready),
    .ds_vec   (rt_vec),
    .ds_mag   (rt_mag)
  );

  vn2d_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .us_valid  (rt_valid),
    .us_ready  (rt_ready),
    .us_vec    (rt_vec),
    .us_mag    (rt_mag),
    .ds_valid  (out_tvalid),
    .ds_ready  (out_tready),
    .ds_vec    (o_vec),
    .ds_mag    (o_mag),
    .ds_unit_x (o_unit_x),
    .ds_unit_y (o_unit_y)
  );

  assign out_tdata = {5'b00000, o_unit_y, o_unit_x, o_mag, o_vec.y, o_vec.x};

endmodule

`default_nettype wire
